// ===== sv/cdq_pkg.sv =====
// cdq_pkg: shared types and codes for the circular deque
// holds action codes, end-value update codes and the stage-one word type
// no dependencies
package cdq_pkg;

  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 32;
  localparam int CAP_W    = 11;

  localparam logic [ACTION_W-1:0] ACT_INS_FRONT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_INS_BACK  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_DEL_FRONT = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_DEL_BACK  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_PEEK      = 3'd4;

  // how a cached end value is refreshed in the second stage
  typedef logic [1:0] upd_t;
  localparam upd_t UPD_KEEP = 2'd0;
  localparam upd_t UPD_WORD = 2'd1;
  localparam upd_t UPD_MEM  = 2'd2;

  typedef struct packed {
    logic                ok;
    logic                empty;
    logic                full;
    upd_t                upd_front;
    upd_t                upd_rear;
    logic [VALUE_W-1:0]  word;
  } s1_t;

endpackage

// ===== sv/cdq_ring.sv =====
// cdq_ring: ring store of the deque, one write port and one read port
// read data is registered; depends on cdq_pkg
module cdq_ring
  import cdq_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [VALUE_W-1:0]       wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [VALUE_W-1:0]       rd_data
);

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/circular_deque.sv =====
// an accepted input word goes to the stage-one register, its result word to the output register
// throughput: one word per cycle while out_tready is high; each item touches at
// most one ring slot (a write for an insert, a read for a delete) through the
// ring store's write port and read port; the two end values are kept in registers
// reset: synchronous, clears pointers, entry count and output valid, and sets
// capacity to DEPTH, at most 2047; the ring store is not cleared
module circular_deque
  import cdq_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: action [2:0], value [34:3], zero fill [39:35]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,
  // out_tdata: ok [0], front_value [32:1], rear_value [64:33],
  // is_empty [65], is_full [66], zero fill [71:67]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int PTRW  = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);
  localparam int CAPX  = (CNTW > CAP_W) ? CNTW : CAP_W;
  localparam int CAP_RST = (DEPTH > 2047) ? 2047 : DEPTH;

  // configuration
  logic [CAP_W-1:0] cap_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & ~cfg_paddr[2];
  assign cfg_prdata = {{(32-CAP_W){1'b0}}, cap_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_W'(CAP_RST);
    end else if (cfg_wr) begin
      cap_r <= cfg_pwdata[CAP_W-1:0];
    end
  end

  logic [CAPX-1:0] cap_x;
  logic [CNTW-1:0] cap_eff;
  logic [PTRW-1:0] cap_m1;

  always_comb begin
    cap_x = CAPX'(cap_r);
    if (cap_x == '0) begin
      cap_eff = CNTW'(1);
    end else if (cap_x > CAPX'(DEPTH)) begin
      cap_eff = CNTW'(DEPTH);
    end else begin
      cap_eff = CNTW'(cap_x);
    end
    cap_m1 = PTRW'(cap_eff - CNTW'(1));
  end

  // pointer state
  logic [PTRW-1:0] front_r, front_nxt;
  logic [PTRW-1:0] back_r, back_nxt;
  logic [CNTW-1:0] count_r, count_nxt;

  logic [PTRW-1:0] front_bk, front_fw, back_bk, back_fw;
  logic            full_now, empty_now;

  // ends step modulo the effective capacity; an end past it wraps
  always_comb begin
    front_fw = (CNTW'(front_r) >= CNTW'(cap_m1)) ? '0 : front_r + PTRW'(1);
    back_fw  = (CNTW'(back_r) >= CNTW'(cap_m1)) ? '0 : back_r + PTRW'(1);
    front_bk = (front_r == '0 || CNTW'(front_r) > cap_eff) ? cap_m1 : front_r - PTRW'(1);
    back_bk  = (back_r == '0 || CNTW'(back_r) > cap_eff) ? cap_m1 : back_r - PTRW'(1);
    full_now  = count_r >= cap_eff;
    empty_now = count_r == '0;
  end

  // handshake
  logic s1_valid_r;
  s1_t  s1_r, s1_nxt;
  logic out_valid_r;
  logic out_free, s1_adv, in_acc;

  assign out_free  = ~out_valid_r | out_tready;
  assign s1_adv    = s1_valid_r & out_free;
  assign in_tready = ~s1_valid_r | out_free;
  assign in_acc    = in_tvalid & in_tready;

  logic [ACTION_W-1:0] in_action;
  logic [VALUE_W-1:0]  in_value;

  assign in_action = in_tdata[ACTION_W-1:0];
  assign in_value  = in_tdata[ACTION_W+VALUE_W-1:ACTION_W];

  // ring store access
  logic               wr_en, rd_en;
  logic [PTRW-1:0]    wr_addr, rd_addr;
  logic [VALUE_W-1:0] rd_data;

  always_comb begin
    front_nxt = front_r;
    back_nxt  = back_r;
    count_nxt = count_r;
    wr_en     = 1'b0;
    wr_addr   = front_r;
    rd_en     = 1'b0;
    rd_addr   = front_r;
    s1_nxt.ok        = 1'b0;
    s1_nxt.upd_front = UPD_KEEP;
    s1_nxt.upd_rear  = UPD_KEEP;
    s1_nxt.word      = in_value;
    if (in_acc) begin
      unique case (in_action)
        ACT_INS_FRONT: begin
          if (!full_now) begin
            s1_nxt.ok = 1'b1;
            count_nxt = count_r + CNTW'(1);
            wr_en     = 1'b1;
            if (empty_now) begin
              front_nxt = '0;
              back_nxt  = '0;
              wr_addr   = '0;
              s1_nxt.upd_front = UPD_WORD;
              s1_nxt.upd_rear  = UPD_WORD;
            end else begin
              front_nxt = front_bk;
              wr_addr   = front_bk;
              s1_nxt.upd_front = UPD_WORD;
              // the slot written may be the one the back end sits on
              if (front_bk == back_r) begin
                s1_nxt.upd_rear = UPD_WORD;
              end
            end
          end
        end
        ACT_INS_BACK: begin
          if (!full_now) begin
            s1_nxt.ok = 1'b1;
            count_nxt = count_r + CNTW'(1);
            wr_en     = 1'b1;
            if (empty_now) begin
              front_nxt = '0;
              back_nxt  = '0;
              wr_addr   = '0;
              s1_nxt.upd_front = UPD_WORD;
              s1_nxt.upd_rear  = UPD_WORD;
            end else begin
              back_nxt = back_fw;
              wr_addr  = back_fw;
              s1_nxt.upd_rear = UPD_WORD;
              if (back_fw == front_r) begin
                s1_nxt.upd_front = UPD_WORD;
              end
            end
          end
        end
        ACT_DEL_FRONT: begin
          if (!empty_now) begin
            s1_nxt.ok = 1'b1;
            count_nxt = count_r - CNTW'(1);
            front_nxt = front_fw;
            rd_en     = 1'b1;
            rd_addr   = front_fw;
            s1_nxt.upd_front = UPD_MEM;
          end
        end
        ACT_DEL_BACK: begin
          if (!empty_now) begin
            s1_nxt.ok = 1'b1;
            count_nxt = count_r - CNTW'(1);
            back_nxt  = back_bk;
            rd_en     = 1'b1;
            rd_addr   = back_bk;
            s1_nxt.upd_rear = UPD_MEM;
          end
        end
        ACT_PEEK: begin
          s1_nxt.ok = 1'b1;
        end
        default: begin
        end
      endcase
    end
    s1_nxt.empty = count_nxt == '0;
    s1_nxt.full  = count_nxt >= cap_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= '0;
      count_r <= '0;
    end else begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
      count_r <= count_nxt;
    end
  end

  cdq_ring #(
    .DEPTH (DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // second stage: refresh cached end values and build the result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
  end

  logic [VALUE_W-1:0] fcache_r, rcache_r;
  logic [VALUE_W-1:0] front_val, rear_val;
  logic [VALUE_W-1:0] front_out, rear_out;

  always_comb begin
    case (s1_r.upd_front)
      UPD_WORD: front_val = s1_r.word;
      UPD_MEM:  front_val = rd_data;
      default:  front_val = fcache_r;
    endcase
    case (s1_r.upd_rear)
      UPD_WORD: rear_val = s1_r.word;
      UPD_MEM:  rear_val = rd_data;
      default:  rear_val = rcache_r;
    endcase
    front_out = s1_r.empty ? {VALUE_W{1'b1}} : front_val;
    rear_out  = s1_r.empty ? {VALUE_W{1'b1}} : rear_val;
  end

  logic [71:0] out_data_r;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      fcache_r   <= front_val;
      rcache_r   <= rear_val;
      out_data_r <= {5'b0, s1_r.full, s1_r.empty, rear_out, front_out, s1_r.ok};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  a_read_feeds_stage: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> s1_valid_r && (s1_r.upd_front == UPD_MEM || s1_r.upd_rear == UPD_MEM))
    else $error("ring read issued without a waiting second-stage word");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && out_valid_r && !out_tready)
    else $error("input stalled with room downstream");

  a_refused_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && full_now && (in_action == ACT_INS_FRONT || in_action == ACT_INS_BACK))
      |=> $stable(count_r) && $stable(front_r) && $stable(back_r))
    else $error("refused insert changed the deque");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && wr_en) |-> count_r < cap_eff)
    else $error("ring write with the deque full");
`endif

endmodule
